>>> rtl/dqms_pkg.sv
// Package with the shared constants, word types and controller types of the deque.
`timescale 1ns / 1ps

package dqms_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned COUNT_OUT_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    MODE_PUSH_HEAD = 3'd0,
    MODE_PUSH_TAIL = 3'd1,
    MODE_POP_HEAD  = 3'd2,
    MODE_POP_TAIL  = 3'd3,
    MODE_SEARCH    = 3'd4,
    MODE_DUMP      = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                     mode;
    logic signed [DATA_W-1:0]  item_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  out_value;
    logic                      found;
    status_e                   status;
    logic [COUNT_OUT_W-1:0]    entry_count;
    logic                      last;
  } out_word_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic exec;
    logic walk_start;
    logic walk_next;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic empty;
    logic is_dump;
    logic is_last;
    logic match;
  } sts_t;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

>>> rtl/dqms_ctrl.sv
// Controller state machine that sequences single operations and entry walks.
`timescale 1ns / 1ps

module dqms_ctrl import dqms_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  mode_e  mode_i,
  input  sts_t   sts_i,
  output logic   in_ready_o,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;
  logic   walk_req;
  logic   scan_done;

  assign walk_req  = ((mode_i == MODE_SEARCH) || (mode_i == MODE_DUMP)) && !sts_i.empty;
  assign scan_done = sts_i.is_dump ? sts_i.is_last : (sts_i.match || sts_i.is_last);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.out_free && walk_req) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.out_free && scan_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          cmd_o.walk_start = walk_req;
          cmd_o.exec       = !walk_req;
        end
      end
      ST_SCAN: begin
        if (sts_i.is_dump) begin
          cmd_o.emit      = sts_i.out_free;
          cmd_o.walk_next = sts_i.out_free && !sts_i.is_last;
        end else if (scan_done) begin
          cmd_o.emit = sts_i.out_free;
        end else begin
          cmd_o.walk_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/dqms_dp.sv
// Datapath with the ring store, head and count registers, walk index and result register.
`timescale 1ns / 1ps

module dqms_dp import dqms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_word_t out_word_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] value_q;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [PTR_W-1:0]  idx_q;
  logic              is_dump_q;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q;
  out_word_t         single_res;
  out_word_t         walk_res;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic              full;
  logic              empty;
  logic              is_last;
  logic              match;

  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);
  assign is_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign match   = (rdata_q == value_q);

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.empty    = empty;
  assign sts_o.is_dump  = is_dump_q;
  assign sts_o.is_last  = is_last;
  assign sts_o.match    = match;

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    wr_en       = 1'b0;
    wr_addr     = ring_add(head_q, count_q[PTR_W-1:0]);
    single_res  = '0;
    single_res.status = STATUS_OK;
    single_res.last   = 1'b1;
    if (cmd_i.exec) begin
      case (in_word_i.mode)
        MODE_PUSH_HEAD: begin
          if (full) begin
            single_res.status = STATUS_FULL;
          end else begin
            head_d  = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
            wr_addr = head_d;
            wr_en   = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        MODE_PUSH_TAIL: begin
          if (full) begin
            single_res.status = STATUS_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        MODE_POP_HEAD: begin
          if (empty) begin
            single_res.status = STATUS_EMPTY;
          end else begin
            head_d  = ring_add(head_q, PTR_W'(1));
            count_d = count_q - CNT_W'(1);
          end
        end
        MODE_POP_TAIL: begin
          if (empty) begin
            single_res.status = STATUS_EMPTY;
          end else begin
            count_d = count_q - CNT_W'(1);
          end
        end
        MODE_DUMP: begin
          single_res.status = STATUS_EMPTY;
        end
        default: ;
      endcase
    end
    single_res.entry_count = COUNT_OUT_W'(count_d);
  end

  always_comb begin
    walk_res             = '0;
    walk_res.status      = STATUS_OK;
    walk_res.entry_count = COUNT_OUT_W'(count_q);
    if (is_dump_q) begin
      walk_res.out_value = rdata_q;
      walk_res.last      = is_last;
    end else begin
      walk_res.found = match;
      walk_res.last  = 1'b1;
    end
  end

  assign rd_en   = cmd_i.walk_start || cmd_i.walk_next;
  assign rd_addr = cmd_i.walk_start ? head_q : ring_add(head_q, idx_q + PTR_W'(1));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_word_i.item_value;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      idx_q     <= '0;
      value_q   <= in_word_i.item_value;
      is_dump_q <= (in_word_i.mode == MODE_DUMP);
    end else if (cmd_i.walk_next) begin
      idx_q <= idx_q + PTR_W'(1);
    end
    if (cmd_i.exec) begin
      out_word_q <= single_res;
    end else if (cmd_i.emit) begin
      out_word_q <= walk_res;
    end
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_i.exec || cmd_i.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds the ring depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec || cmd_i.emit) |-> sts_o.out_free)
    else $error("result register overwritten while still held");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_next |-> !is_last)
    else $error("walk advanced beyond the tail entry");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && !full && (in_word_i.mode == MODE_PUSH_HEAD ||
                             in_word_i.mode == MODE_PUSH_TAIL))
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("accepted push did not grow the entry count");

endmodule

>>> rtl/deque_with_membership_search.sv
// Top level of the bounded double-ended queue with membership search and dump.
`timescale 1ns / 1ps

// A ring of 16 signed 32-bit entries used as a deque. Pushes, pops, unused
// mode codes, and a search or dump of an empty queue are done at the edge the
// word is accepted and give their single result word in the cycle after. A search
// reads one stored entry per cycle from head toward tail through the single
// registered read port of the ring, stopping at the first equal entry. A dump
// uses the same port and gives one result word per cycle while the output is
// not stalled. A new word is taken once the walk of the previous one has
// finished and the result register is free or being drained.
module deque_with_membership_search import dqms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  cmd_t cmd;
  sts_t sts;

  dqms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (in_word_i.mode),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  dqms_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

>>> bench/tb_deque_with_membership_search.sv
// Self-checking testbench for the deque with membership search and dump.
`timescale 1ns / 1ps

module tb_deque_with_membership_search;
  import dqms_pkg::*;

  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam int RANDOM_WORDS = 100;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES = 200000;
  localparam int NROWS = 25;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;
    logic [4:0]  reps;
    logic        pinned;
    logic        pin_found;
    status_e     pin_status;
    logic [4:0]  pin_count;
  } row_t;

  typedef struct packed {
    logic      pinned;
    out_word_t pin;
  } offer_t;

  localparam row_t DIRECTED [NROWS] = '{
    '{MODE_POP_HEAD,  32'h0000_0000, 5'd1,  1'b1, 1'b0, STATUS_EMPTY, 5'd0},
    '{MODE_POP_TAIL,  32'h0000_0000, 5'd1,  1'b1, 1'b0, STATUS_EMPTY, 5'd0},
    '{MODE_DUMP,      32'h0000_0000, 5'd1,  1'b1, 1'b0, STATUS_EMPTY, 5'd0},
    '{MODE_SEARCH,    32'h0000_0000, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd0},
    '{MODE_SPARE_6,   32'hFFFF_FFFF, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd0},
    '{MODE_SPARE_7,   32'h0000_0000, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd0},
    '{MODE_PUSH_TAIL, 32'h7FFF_FFFF, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd1},
    '{MODE_PUSH_HEAD, 32'h8000_0000, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd2},
    '{MODE_PUSH_TAIL, 32'hFFFF_FFFF, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd3},
    '{MODE_PUSH_HEAD, 32'h0000_0000, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd4},
    '{MODE_SEARCH,    32'h8000_0000, 5'd1,  1'b1, 1'b1, STATUS_OK,    5'd4},
    '{MODE_SEARCH,    32'h7FFF_FFFE, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd4},
    '{MODE_SEARCH,    32'h0000_0001, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd4},
    '{MODE_DUMP,      32'h0000_0000, 5'd1,  1'b0, 1'b0, STATUS_OK,    5'd0},
    '{MODE_POP_HEAD,  32'h0000_0000, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd3},
    '{MODE_POP_TAIL,  32'h0000_0000, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd2},
    '{MODE_SEARCH,    32'hFFFF_FFFF, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd2},
    '{MODE_PUSH_TAIL, 32'h5A5A_5A5A, 5'd14, 1'b0, 1'b0, STATUS_OK,    5'd0},
    '{MODE_PUSH_HEAD, 32'h0000_0001, 5'd1,  1'b1, 1'b0, STATUS_FULL,  5'd16},
    '{MODE_PUSH_TAIL, 32'h0000_0001, 5'd1,  1'b1, 1'b0, STATUS_FULL,  5'd16},
    '{MODE_SEARCH,    32'h5A5A_5A5A, 5'd1,  1'b1, 1'b1, STATUS_OK,    5'd16},
    '{MODE_DUMP,      32'h0000_0000, 5'd1,  1'b0, 1'b0, STATUS_OK,    5'd0},
    '{MODE_SPARE_7,   32'h1234_5678, 5'd1,  1'b1, 1'b0, STATUS_OK,    5'd16},
    '{MODE_POP_HEAD,  32'h0000_0000, 5'd16, 1'b0, 1'b0, STATUS_OK,    5'd0},
    '{MODE_DUMP,      32'h0000_0000, 5'd1,  1'b1, 1'b0, STATUS_EMPTY, 5'd0}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  logic signed [DATA_W-1:0] ring_copy [DEPTH];
  int unsigned head_copy = 0;
  int unsigned held_copy = 0;

  out_word_t owed_words_q [$];
  offer_t    offered_q [$];

  int mismatches = 0;
  int words_in = 0;
  int words_checked = 0;
  int dump_words = 0;
  int dropped_pushes = 0;
  int empty_reports = 0;
  int search_hits = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit hold_wanted = 1'b0;

  deque_with_membership_search i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void deque_op(input in_word_t w);
    out_word_t r;
    r = '0;
    r.status = STATUS_OK;
    r.last = 1'b1;
    case (w.mode)
      MODE_PUSH_HEAD, MODE_PUSH_TAIL: begin
        if (held_copy == DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          if (w.mode == MODE_PUSH_HEAD) begin
            head_copy = (head_copy + DEPTH - 1) % DEPTH;
            ring_copy[head_copy] = w.item_value;
          end else begin
            ring_copy[(head_copy + held_copy) % DEPTH] = w.item_value;
          end
          held_copy++;
        end
      end
      MODE_POP_HEAD, MODE_POP_TAIL: begin
        if (held_copy == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          if (w.mode == MODE_POP_HEAD) begin
            head_copy = (head_copy + 1) % DEPTH;
          end
          held_copy--;
        end
      end
      MODE_SEARCH: begin
        for (int k = 0; k < held_copy; k++) begin
          if (ring_copy[(head_copy + k) % DEPTH] == w.item_value) begin
            r.found = 1'b1;
          end
        end
      end
      MODE_DUMP: begin
        if (held_copy == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          for (int k = 0; k < held_copy; k++) begin
            r.out_value = ring_copy[(head_copy + k) % DEPTH];
            r.entry_count = COUNT_OUT_W'(held_copy);
            r.last = (k == held_copy - 1);
            owed_words_q.push_back(r);
            dump_words++;
          end
          return;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = COUNT_OUT_W'(held_copy);
    owed_words_q.push_back(r);
  endfunction

  function automatic void check_word(input out_word_t got);
    out_word_t want;
    words_checked++;
    if (owed_words_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Unexpected result word: value %0d found %0b status %0d count %0d last %0b",
                 got.out_value, got.found, got.status, got.entry_count, got.last);
      end
      return;
    end
    want = owed_words_q.pop_front();
    if (got.out_value !== want.out_value || got.found !== want.found ||
        got.status !== want.status || got.entry_count !== want.entry_count ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch on result word %0d: expected value %0d found %0b status %0d",
                 words_checked, want.out_value, want.found, want.status);
        $display("  count %0d last %0b; got value %0d found %0b status %0d count %0d last %0b",
                 want.entry_count, want.last, got.out_value, got.found, got.status,
                 got.entry_count, got.last);
      end
    end
    if (got.status == STATUS_FULL) dropped_pushes++;
    if (got.status == STATUS_EMPTY) empty_reports++;
    if (got.found) search_hits++;
  endfunction

  always @(posedge clk_i) begin
    offer_t rec;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_word(out_word_o);
      end
      if (in_valid_i && in_ready_o) begin
        rec = offered_q.pop_front();
        deque_op(in_word_i);
        if (rec.pinned) begin
          owed_words_q[$] = rec.pin;
        end
        words_in++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d result words owed", cycle_count,
               owed_words_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int seg_len;
    int pct;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      seg_len = $urandom_range(4, 30);
      case ($urandom_range(0, 3))
        0: pct = 100;
        1: pct = 75;
        2: pct = 50;
        default: pct = 25;
      endcase
      repeat (seg_len) begin
        out_ready_i <= ($urandom_range(0, 99) < pct);
        @(posedge clk_i);
      end
    end
  end

  task automatic offer_word(input logic [2:0] mode, input logic [31:0] value,
                            input logic pinned, input out_word_t pin);
    in_word_t w;
    offer_t rec;
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    w.mode = mode_e'(mode);
    w.item_value = value;
    rec.pinned = pinned;
    rec.pin = pin;
    offered_q.push_back(rec);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    out_word_t pin;
    logic [31:0] recent [8];
    logic [31:0] value;
    logic [2:0] mode;
    int slot;
    int p;
    bit filling;
    slot = 0;
    filling = 1'b1;
    foreach (recent[k]) recent[k] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NROWS; r++) begin
      pin = '0;
      pin.found = DIRECTED[r].pin_found;
      pin.status = DIRECTED[r].pin_status;
      pin.entry_count = DIRECTED[r].pin_count;
      pin.last = 1'b1;
      for (int n = 0; n < DIRECTED[r].reps; n++) begin
        offer_word(DIRECTED[r].mode, DIRECTED[r].value, DIRECTED[r].pinned, pin);
      end
    end

    hold_wanted = 1'b1;
    pin = '0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 11) == 0) filling = !filling;
      p = $urandom_range(0, 99);
      if (p >= 96) begin
        mode = p[0] ? MODE_SPARE_7 : MODE_SPARE_6;
      end else if (p < (filling ? 55 : 20)) begin
        mode = p[0] ? MODE_PUSH_HEAD : MODE_PUSH_TAIL;
      end else if (p < 75) begin
        mode = p[0] ? MODE_POP_HEAD : MODE_POP_TAIL;
      end else if (p < 88) begin
        mode = MODE_SEARCH;
      end else begin
        mode = MODE_DUMP;
      end
      case ($urandom_range(0, 7))
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        2: value = 32'hFFFF_FFFF;
        3: value = 32'h0000_0000;
        default: value = $urandom;
      endcase
      if (mode == MODE_SEARCH && $urandom_range(0, 1) == 1) begin
        value = recent[$urandom_range(0, 7)];
      end
      if (mode == MODE_PUSH_HEAD || mode == MODE_PUSH_TAIL) begin
        recent[slot] = value;
        slot = (slot + 1) % 8;
      end
      offer_word(mode, value, 1'b0, pin);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d input words and checked %0d result words, %0d of them dump entries.",
             words_in, words_checked, dump_words);
    $display("Seen %0d dropped pushes, %0d empty reports and %0d search hits.",
             dropped_pushes, empty_reports, search_hits);
    if (mismatches == 0 && owed_words_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/dqms_pkg.sv
rtl/dqms_ctrl.sv
rtl/dqms_dp.sv
rtl/deque_with_membership_search.sv
bench/tb_deque_with_membership_search.sv
